// ===== src/frd_pkg.sv =====
// Shared types and constants for the fraction reduction block.
// No dependencies; imported by every module of the block.
`default_nettype none

package frd_pkg;

  // width of one signed operand
  localparam int unsigned VALUE_WIDTH = 32;
  // width of an effective (positive) operand and of a result field
  localparam int unsigned OP_WIDTH = VALUE_WIDTH - 1;
  // width of the subtractor, one bit above an operand for the division trial
  localparam int unsigned SUB_WIDTH = VALUE_WIDTH;
  // shift count for the common power of two
  localparam int unsigned SHIFT_WIDTH = $clog2(OP_WIDTH);
  // divider step counter
  localparam int unsigned CNT_WIDTH = $clog2(OP_WIDTH);
  localparam logic [CNT_WIDTH-1:0] LAST_STEP = CNT_WIDTH'(OP_WIDTH - 1);

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] numerator;
    logic signed [VALUE_WIDTH-1:0] denominator;
  } frd_req_t;

  typedef struct packed {
    logic [OP_WIDTH-1:0] reduced_numerator;
    logic [OP_WIDTH-1:0] reduced_denominator;
  } frd_res_t;

  // flags from the shared subtractor
  typedef struct packed {
    logic borrow;
    logic zero;
  } frd_flags_t;

  // any operand below two, negatives included, acts as one
  function automatic logic [OP_WIDTH-1:0] effective_op(input logic [VALUE_WIDTH-1:0] raw);
    logic [OP_WIDTH-1:0] one;
    one = OP_WIDTH'(1);
    if (raw[VALUE_WIDTH-1] || (raw[OP_WIDTH-1:1] == '0)) begin
      return one;
    end
    return raw[OP_WIDTH-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/frd_alu.sv =====
// Shared subtract unit used by both the gcd loop and the divider.
// Depends on frd_pkg.
`default_nettype none

module frd_alu import frd_pkg::*; (
  input  wire logic [SUB_WIDTH-1:0] x_i,
  input  wire logic [SUB_WIDTH-1:0] y_i,
  output logic      [SUB_WIDTH-1:0] diff_o,
  output frd_flags_t                flags_o
);

  logic [SUB_WIDTH:0] full;

  // one wide subtract with borrow out
  assign full            = {1'b0, x_i} - {1'b0, y_i};
  assign diff_o          = full[SUB_WIDTH-1:0];
  assign flags_o.borrow  = full[SUB_WIDTH];
  assign flags_o.zero    = (full == '0);

endmodule

`default_nettype wire

// ===== src/fraction_reduction_top.sv =====
// Fraction reduction top level: binary gcd then two restoring divisions.
// Depends on frd_pkg and frd_alu.
//
//   channel   signals                   direction   meaning
//   request   start, busy, req_i        in          numerator and denominator
//   result    done_o, res_o             out         reduced fraction, one cycle
//
// A request is taken when start is high and busy is low; busy then stays high
// until the result strobe. The gcd loop performs one shift, swap or subtract
// step per cycle, then both divisions run on the shared subtractor, one after
// the other. done_o is high for one cycle with busy already low, so the next
// start may come in that cycle. Reset is asynchronous and clears control
// state only. The receiver cannot stall.
`default_nettype none

module fraction_reduction_top import frd_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire frd_req_t req_i,
  output logic          done_o,
  output frd_res_t      res_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GCD,
    ST_DIVN,
    ST_DIVD
  } state_e;

  state_e                state_q;
  logic [OP_WIDTH-1:0]   a_q, b_q, n_q, d_q, g_q, rem_q, quo_q, resn_q;
  logic [SHIFT_WIDTH-1:0] k_q;
  logic [CNT_WIDTH-1:0]  cnt_q;
  logic                  done_q;
  frd_res_t              res_q;

  logic [SUB_WIDTH-1:0]  alu_x, alu_y, alu_diff;
  frd_flags_t            alu_flags;
  logic [SUB_WIDTH-1:0]  trial;
  logic [OP_WIDTH-1:0]   rem_d;
  logic [OP_WIDTH-1:0]   quo_d;

  // division trial: remainder shifted left with the next dividend bit
  assign trial = {rem_q, quo_q[OP_WIDTH-1]};

  // shared subtractor operand select
  always_comb begin
    alu_x = {1'b0, a_q};
    alu_y = {1'b0, b_q};
    if (state_q == ST_DIVN || state_q == ST_DIVD) begin
      alu_x = trial;
      alu_y = {1'b0, g_q};
    end
  end

  frd_alu u_alu (
    .x_i     (alu_x),
    .y_i     (alu_y),
    .diff_o  (alu_diff),
    .flags_o (alu_flags)
  );

  // restoring division step
  always_comb begin
    if (alu_flags.borrow) begin
      rem_d = trial[OP_WIDTH-1:0];
    end else begin
      rem_d = alu_diff[OP_WIDTH-1:0];
    end
    quo_d = {quo_q[OP_WIDTH-2:0], ~alu_flags.borrow};
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

  // sequencer and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            a_q     <= effective_op(req_i.numerator);
            b_q     <= effective_op(req_i.denominator);
            n_q     <= effective_op(req_i.numerator);
            d_q     <= effective_op(req_i.denominator);
            k_q     <= '0;
            state_q <= ST_GCD;
          end
        end
        ST_GCD: begin
          // binary gcd, one step per cycle
          priority if (alu_flags.zero) begin
            g_q     <= a_q << k_q;
            rem_q   <= '0;
            quo_q   <= n_q;
            cnt_q   <= '0;
            state_q <= ST_DIVN;
          end else if (!a_q[0] && !b_q[0]) begin
            a_q <= a_q >> 1;
            b_q <= b_q >> 1;
            k_q <= k_q + SHIFT_WIDTH'(1);
          end else if (!a_q[0]) begin
            a_q <= a_q >> 1;
          end else if (!b_q[0]) begin
            b_q <= b_q >> 1;
          end else if (alu_flags.borrow) begin
            a_q <= b_q;
            b_q <= a_q;
          end else begin
            a_q <= alu_diff[OP_WIDTH:1];
          end
        end
        ST_DIVN: begin
          rem_q <= rem_d;
          quo_q <= quo_d;
          cnt_q <= cnt_q + CNT_WIDTH'(1);
          if (cnt_q == LAST_STEP) begin
            resn_q  <= quo_d;
            rem_q   <= '0;
            quo_q   <= d_q;
            cnt_q   <= '0;
            state_q <= ST_DIVD;
          end
        end
        ST_DIVD: begin
          rem_q <= rem_d;
          quo_q <= quo_d;
          cnt_q <= cnt_q + CNT_WIDTH'(1);
          if (cnt_q == LAST_STEP) begin
            res_q.reduced_numerator   <= resn_q;
            res_q.reduced_denominator <= quo_d;
            done_q                    <= 1'b1;
            state_q                   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/frd_checker.sv =====
// Port-level checker for the fraction reduction block, bound to the top.
// Depends on frd_pkg.
`default_nettype none

module frd_port_assertions import frd_pkg::*; (
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     start,
  input wire logic     busy,
  input wire logic     done_o,
  input wire frd_res_t res_o
);

  // a taken request makes the block busy
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("request taken but block not busy");

  // the result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // busy only ends with a result
  a_busy_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("busy dropped without a result");

  // reduced values are never zero
  a_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.reduced_numerator != '0) && (res_o.reduced_denominator != '0))
    else $error("zero in reduced fraction");

endmodule

bind fraction_reduction_top frd_port_assertions u_frd_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o),
  .res_o  (res_o)
);

`default_nettype wire
